### src/srwq_pkg.sv
// ----------------------------------------------------------------------------
// srwq_pkg
// shared sizes, codes and beat types of the segmented report write queue
// ----------------------------------------------------------------------------
package srwq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int ENTRY_BYTES = 62;
    localparam int SEG_PAYLOAD = 18;
    localparam int OUT_CHARS   = 10;

    // one spare slot holds the write being assembled
    localparam int SLOTS  = QUEUE_DEPTH + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_N  = (ENTRY_BYTES > SEG_PAYLOAD) ? ENTRY_BYTES : SEG_PAYLOAD + 1;
    localparam int POS_W  = $clog2(POS_N);
    localparam int LEN_W  = $clog2(ENTRY_BYTES + 1);
    localparam int STG_W  = $clog2(POS_N + 1);
    localparam int ADDR_W = SLOT_W + POS_W;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_DRAIN  = 2'd2;

    localparam logic [1:0] MODE_FEATURE = 2'd0;
    localparam logic [1:0] MODE_ROUTE   = 2'd1;
    localparam logic [1:0] MODE_DROP    = 2'd2;

    localparam logic CFG_LINK_READY    = 1'b0;
    localparam logic CFG_REPORT_HANDLE = 1'b1;

    localparam logic [7:0] ID_ROUTE_LO = 8'h80;
    localparam logic [7:0] ID_ROUTE_HI = 8'h89;
    localparam logic [7:0] HDR_BASE    = 8'h80;
    localparam logic [7:0] HDR_LAST    = 8'h40;
    localparam logic [7:0] PROP_WRITE  = 8'h0C;
    localparam logic [7:0] UUID_LO     = 8'hB5;
    localparam logic [7:0] UUID_HI     = 8'hBE;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] char_handle;
        logic [7:0]  char_props;
        logic [7:0]  uuid_last;
        logic [7:0]  data_byte;
        logic [15:0] body_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  write_byte;
        logic [15:0] write_handle;
        logic [5:0]  write_length;
        logic        last_of_write;
        logic        queue_empty;
    } t_out_item;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } t_byte_wr;

    typedef struct packed {
        logic             en;
        logic [15:0]      handle;
        logic [LEN_W-1:0] len;
        logic             hdr_en;
        logic [7:0]       hdr;
    } t_push;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_drain_state;

endpackage

### src/srwq_byte_ram.sv
// ----------------------------------------------------------------------------
// srwq_byte_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module srwq_byte_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/srwq_frame.sv
// ----------------------------------------------------------------------------
// srwq_frame
// handle table, report parsing and segmentation into queue writes
// ----------------------------------------------------------------------------
module srwq_frame
    import srwq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rec_en,
    input  logic        i_byte_en,
    input  t_in_item    i_item,
    input  logic [15:0] i_report_handle,
    output t_byte_wr    o_wr,
    output t_push       o_push
);

    localparam int FL_W = STG_W + 1;

    logic [15:0]      r_tbl [OUT_CHARS];
    logic             r_in_report, n_in_report;
    logic [15:0]      r_expect, n_expect;
    logic [LEN_W-1:0] r_kept, n_kept;
    logic [15:0]      r_pos, n_pos;
    logic [2:0]       r_seg, n_seg;
    logic [1:0]       r_mode, n_mode;
    logic [STG_W-1:0] r_stage, n_stage;
    logic [15:0]      r_handle, n_handle;

    logic [7:0]       rid;
    logic [15:0]      blen;
    logic [LEN_W-1:0] kept_new;
    logic             hit_route;
    logic [15:0]      lk_handle;
    logic [15:0]      pos_new;
    logic             pos_last;
    logic             fa_en;
    logic             fa_last;
    logic [STG_W-1:0] fa_stage;
    logic [STG_W-1:0] fa_new;
    logic [2:0]       fa_seq;
    logic [FL_W-1:0]  fa_len;
    logic [STG_W-1:0] rt_new;
    logic [7:0]       rec_idx;
    logic             rec_hit;
    t_byte_wr         wr;
    t_push            push;

    always_comb begin
        n_in_report = r_in_report;
        n_expect    = r_expect;
        n_kept      = r_kept;
        n_pos       = r_pos;
        n_seg       = r_seg;
        n_mode      = r_mode;
        n_stage     = r_stage;
        n_handle    = r_handle;
        wr          = '0;
        push        = '0;
        rid         = i_item.data_byte;
        blen        = i_item.body_len;
        kept_new    = (blen > 16'(ENTRY_BYTES)) ? LEN_W'(ENTRY_BYTES) : LEN_W'(blen);
        hit_route   = (rid >= ID_ROUTE_LO) && (rid <= ID_ROUTE_HI);
        lk_handle   = '0;
        for (int i = 0; i < OUT_CHARS; i++) begin
            if (rid[3:0] == 4'(i)) begin
                lk_handle = r_tbl[i];
            end
        end
        pos_new  = r_pos + 16'd1;
        pos_last = (pos_new == 16'(r_kept));
        fa_en    = 1'b0;
        fa_last  = 1'b0;
        fa_stage = r_stage;
        fa_seq   = r_seg;
        fa_new   = '0;
        fa_len   = '0;
        rt_new   = r_stage + STG_W'(1);

        if (i_byte_en) begin
            if (!r_in_report) begin
                // id beat
                n_expect    = blen;
                n_kept      = kept_new;
                n_pos       = '0;
                n_seg       = '0;
                n_stage     = '0;
                n_in_report = (blen != 16'd0);
                if (hit_route) begin
                    n_mode   = ((lk_handle == 16'd0) || (blen == 16'd0)) ? MODE_DROP
                                                                         : MODE_ROUTE;
                    n_handle = lk_handle;
                end else begin
                    n_mode   = MODE_FEATURE;
                    n_handle = i_report_handle;
                    fa_en    = 1'b1;
                    fa_last  = (kept_new == '0);
                    fa_stage = '0;
                    fa_seq   = '0;
                end
            end else begin
                if (pos_new <= 16'(r_kept)) begin
                    case (r_mode)
                        MODE_ROUTE: begin
                            wr.en   = 1'b1;
                            wr.pos  = POS_W'(r_stage);
                            wr.data = rid;
                            if (pos_last) begin
                                push.en     = 1'b1;
                                push.handle = r_handle;
                                push.len    = LEN_W'(rt_new);
                                n_stage     = '0;
                            end else begin
                                n_stage = rt_new;
                            end
                        end
                        MODE_FEATURE: begin
                            fa_en   = 1'b1;
                            fa_last = pos_last;
                        end
                        default: ;
                    endcase
                end
                if (pos_new >= r_expect) begin
                    n_in_report = 1'b0;
                    n_pos       = '0;
                end else begin
                    n_pos = pos_new;
                end
            end
        end

        // segment byte lands after the header position
        if (fa_en) begin
            fa_new  = fa_stage + STG_W'(1);
            wr.en   = 1'b1;
            wr.pos  = POS_W'(fa_new);
            wr.data = rid;
            if ((fa_new >= STG_W'(SEG_PAYLOAD)) || fa_last) begin
                fa_len      = {1'b0, fa_new} + FL_W'(1);
                push.en     = 1'b1;
                push.handle = n_handle;
                push.len    = (fa_len > FL_W'(ENTRY_BYTES)) ? LEN_W'(ENTRY_BYTES)
                                                            : LEN_W'(fa_len);
                push.hdr_en = 1'b1;
                push.hdr    = HDR_BASE | {5'b0, fa_seq} | (fa_last ? HDR_LAST : 8'h00);
                n_seg       = fa_seq + 3'd1;
                n_stage     = '0;
            end else begin
                n_stage = fa_new;
            end
        end
    end

    assign rec_idx = i_item.uuid_last - UUID_LO;
    assign rec_hit = i_rec_en && ((i_item.char_props & PROP_WRITE) != 8'h00)
                     && (i_item.uuid_last >= UUID_LO) && (i_item.uuid_last <= UUID_HI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < OUT_CHARS; i++) begin
                r_tbl[i] <= '0;
            end
            r_in_report <= 1'b0;
            r_expect    <= '0;
            r_kept      <= '0;
            r_pos       <= '0;
            r_seg       <= '0;
            r_mode      <= MODE_FEATURE;
            r_stage     <= '0;
            r_handle    <= '0;
        end else begin
            for (int i = 0; i < OUT_CHARS; i++) begin
                if (rec_hit && (rec_idx[3:0] == 4'(i))) begin
                    r_tbl[i] <= i_item.char_handle;
                end
            end
            r_in_report <= n_in_report;
            r_expect    <= n_expect;
            r_kept      <= n_kept;
            r_pos       <= n_pos;
            r_seg       <= n_seg;
            r_mode      <= n_mode;
            r_stage     <= n_stage;
            r_handle    <= n_handle;
        end
    end

    assign o_wr   = wr;
    assign o_push = push;

endmodule

### src/srwq_queue.sv
// ----------------------------------------------------------------------------
// srwq_queue
// ring of write slots, drain sequencer and two beat output buffer
// ----------------------------------------------------------------------------
module srwq_queue
    import srwq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_gate,
    input  logic              i_drain,
    input  t_push             i_push,
    output logic [SLOT_W-1:0] o_head,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    output logic              o_busy
);

    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    t_drain_state      r_state, n_state;
    logic [SLOT_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_k, n_k;
    logic              r_rd_pend, n_rd_pend;
    logic              r_rd_last, n_rd_last;
    logic              r_rd_first, n_rd_first;

    logic [15:0]       r_m_handle [SLOTS];
    logic [LEN_W-1:0]  r_m_len [SLOTS];
    logic              r_m_hdr_en [SLOTS];
    logic [7:0]        r_m_hdr [SLOTS];

    logic [LEN_W-1:0]  r_len;
    logic [15:0]       r_handle;
    logic              r_hdr_en;
    logic [7:0]        r_hdr;

    t_out_item         r_fifo [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_occ;

    logic [SLOT_W-1:0] head_inc;
    logic [SLOT_W-1:0] tail_inc;
    logic              start;
    logic              empty_push;
    logic              pop;
    logic              room;
    logic              issue;
    logic              fifo_push;
    t_out_item         push_item;

    assign head_inc   = (r_head == SLOT_W'(SLOTS - 1)) ? '0 : r_head + SLOT_W'(1);
    assign tail_inc   = (r_tail == SLOT_W'(SLOTS - 1)) ? '0 : r_tail + SLOT_W'(1);
    assign start      = i_drain && i_gate && (r_count != '0);
    assign empty_push = i_drain && !(i_gate && (r_count != '0));
    assign pop        = (r_occ != 2'd0) && !i_out_stall;
    assign room       = (({1'b0, r_occ} + {2'b0, r_rd_pend}) < 3'd2) || pop;
    assign issue      = (r_state == ST_READ) && room;
    assign fifo_push  = r_rd_pend || empty_push;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_state    = r_state;
        n_k        = r_k;
        n_rd_pend  = 1'b0;
        n_rd_last  = r_rd_last;
        n_rd_first = r_rd_first;
        if (i_push.en) begin
            n_head = head_inc;
            // full: oldest write is dropped
            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                n_tail = tail_inc;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
        if (start) begin
            n_tail  = tail_inc;
            n_count = r_count - CNT_W'(1);
            n_state = ST_READ;
            n_k     = '0;
        end
        if (issue) begin
            n_k        = r_k + LEN_W'(1);
            n_rd_pend  = 1'b1;
            n_rd_first = (r_k == '0);
            n_rd_last  = (r_k == (r_len - LEN_W'(1)));
            if (r_k == (r_len - LEN_W'(1))) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_comb begin
        push_item = '0;
        if (empty_push) begin
            push_item.queue_empty = 1'b1;
        end else begin
            push_item.write_byte    = (r_rd_first && r_hdr_en) ? r_hdr : i_rd_data;
            push_item.write_handle  = r_handle;
            push_item.write_length  = 6'(r_len);
            push_item.last_of_write = r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_state    <= ST_IDLE;
            r_k        <= '0;
            r_rd_pend  <= 1'b0;
            r_rd_last  <= 1'b0;
            r_rd_first <= 1'b0;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_occ      <= 2'd0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_state    <= n_state;
            r_k        <= n_k;
            r_rd_pend  <= n_rd_pend;
            r_rd_last  <= n_rd_last;
            r_rd_first <= n_rd_first;
            r_wp       <= r_wp ^ fifo_push;
            r_rp       <= r_rp ^ pop;
            r_occ      <= r_occ + {1'b0, fifo_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.en) begin
            r_m_handle[r_head] <= i_push.handle;
            r_m_len[r_head]    <= i_push.len;
            r_m_hdr_en[r_head] <= i_push.hdr_en;
            r_m_hdr[r_head]    <= i_push.hdr;
        end
        if (start) begin
            r_slot   <= r_tail;
            r_len    <= r_m_len[r_tail];
            r_handle <= r_m_handle[r_tail];
            r_hdr_en <= r_m_hdr_en[r_tail];
            r_hdr    <= r_m_hdr[r_tail];
        end
        if (fifo_push) begin
            r_fifo[r_wp] <= push_item;
        end
    end

    assign o_head      = r_head;
    assign o_rd_en     = issue;
    assign o_rd_addr   = {r_slot, POS_W'(r_k)};
    assign o_out_valid = (r_occ != 2'd0);
    assign o_out_item  = r_fifo[r_rp];
    assign o_busy      = (r_state != ST_IDLE) || r_rd_pend || (r_occ != 2'd0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= 2'd2)
        else $error("output buffer overfilled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_pend && (r_occ == 2'd2)))
        else $error("read return with full output buffer");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_drain |-> ((r_state == ST_IDLE) && !r_rd_pend && (r_occ == 2'd0)))
        else $error("drain started while busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && r_rd_last) |-> (r_state == ST_IDLE))
        else $error("sequencer still reading after last beat");

endmodule

### src/segmented_report_write_queue_unit.sv
// ----------------------------------------------------------------------------
// segmented_report_write_queue_unit
// queues report bytes as characteristic writes and drains them beat by beat
// ----------------------------------------------------------------------------
// Records and report bytes can stream in back to back. A drain of a queued
// write of n bytes holds off further input until the cycle after its last
// beat is taken. The bytes come out of the single read port of the entry ram
// at one per cycle while the output does not stall. A drain that finds
// nothing, or finds the link gated (not ready or a zero report handle),
// gives one queue_empty beat. Written data bytes sit in the entry ram and
// header bytes in per-slot registers, one spare slot beyond the queue depth
// holding the write being assembled.
module segmented_report_write_queue_unit
    import srwq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic              r_link_ready;
    logic [15:0]       r_report_handle;
    logic              gate;
    logic              in_acc;
    logic              busy;
    logic              rec_en;
    logic              byte_en;
    logic              drain;
    t_byte_wr          wr;
    t_push             push;
    logic [SLOT_W-1:0] head;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_ready    <= 1'b0;
            r_report_handle <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINK_READY:    r_link_ready    <= i_cfg_data[0];
                CFG_REPORT_HANDLE: r_report_handle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign gate       = r_link_ready && (r_report_handle != 16'd0);
    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !busy;
    assign rec_en     = in_acc && (i_in_item.operation == OP_RECORD);
    assign byte_en    = in_acc && (i_in_item.operation == OP_REPORT) && gate;
    assign drain      = in_acc && (i_in_item.operation == OP_DRAIN);

    srwq_frame u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec_en        (rec_en),
        .i_byte_en       (byte_en),
        .i_item          (i_in_item),
        .i_report_handle (r_report_handle),
        .o_wr            (wr),
        .o_push          (push)
    );

    srwq_byte_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr ({head, wr.pos}),
        .i_wr_data (wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    srwq_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gate      (gate),
        .i_drain     (drain),
        .i_push      (push),
        .o_head      (head),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_busy      (busy)
    );

endmodule
